### rtl/telnet_option_responder_assert.svh
// Assertion macros for the telnet option responder, used by tor_back.
// Uses signals clk and arst_n from the including module; no other dependencies.
`ifndef TELNET_OPTION_RESPONDER_ASSERT_SVH
`define TELNET_OPTION_RESPONDER_ASSERT_SVH

// Concurrent check sampled on clk, disabled while reset is asserted.
`define TOR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication built on the macro above.
`define TOR_ASSERT_IMP(lbl, ante, cons, msg) \
	`TOR_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

### rtl/tor_pkg.sv
// Shared types, telnet codes and the terminal-type reply table.
// No dependencies; used by every module of the telnet option responder.
package tor_pkg;

	localparam logic [7:0] IAC  = 8'd255;
	localparam logic [7:0] DONT = 8'd254;
	localparam logic [7:0] DO   = 8'd253;
	localparam logic [7:0] WONT = 8'd252;
	localparam logic [7:0] WILL = 8'd251;
	localparam logic [7:0] SB   = 8'd250;
	localparam logic [7:0] SE   = 8'd240;

	localparam logic [7:0] OPT_ECHO  = 8'd1;
	localparam logic [7:0] OPT_SGA   = 8'd3;
	localparam logic [7:0] OPT_TTYPE = 8'd24;

	localparam int QUEUE_DEPTH = 2;

	localparam int TTYPE_LEN = 10;
	localparam int IDX_W     = $clog2(TTYPE_LEN);
	localparam logic [IDX_W-1:0] REPLY_LAST_IDX = IDX_W'(2);
	localparam logic [IDX_W-1:0] TTYPE_LAST_IDX = IDX_W'(TTYPE_LEN - 1);

	typedef enum logic [1:0] {
		PH_DATA,
		PH_CMD,
		PH_OPT,
		PH_SB
	} phase_t;

	typedef enum logic [1:0] {
		JOB_PASS,
		JOB_REPLY,
		JOB_TTYPE
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] cmd;
		logic [7:0] data;
	} job_t;

	// IAC SB TERMINAL-TYPE IS "ANSI" IAC SE
	function automatic logic [7:0] ttype_byte(input logic [IDX_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0:    b = IAC;
			4'd1:    b = SB;
			4'd2:    b = OPT_TTYPE;
			4'd3:    b = 8'd0;
			4'd4:    b = 8'd65;
			4'd5:    b = 8'd78;
			4'd6:    b = 8'd83;
			4'd7:    b = 8'd73;
			4'd8:    b = IAC;
			4'd9:    b = SE;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

### rtl/tor_front.sv
// Front end: tracks the telnet command phase and turns each received byte
// that calls for output into an output job. Depends on tor_pkg.
module tor_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    rx_byte,
	input  logic          end_of_read,
	input  logic          q_full,
	output logic          q_push,
	output tor_pkg::job_t q_job
);
	import tor_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] held_q;
	logic       accept;
	logic       sb_end;
	logic       push;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	assign sb_end   = (rx_byte == SE) || end_of_read;
	assign q_push   = accept && push;

	always_comb begin
		phase_d     = phase_q;
		push        = 1'b0;
		q_job.kind  = JOB_PASS;
		q_job.cmd   = held_q;
		q_job.data  = rx_byte;
		case (phase_q)
			PH_DATA: begin
				if (rx_byte == IAC) begin
					phase_d = PH_CMD;
				end else begin
					push = 1'b1;
				end
			end
			PH_CMD: begin
				phase_d = PH_OPT;
			end
			PH_OPT: begin
				phase_d    = PH_DATA;
				q_job.kind = JOB_REPLY;
				if (held_q == DO && (rx_byte == OPT_SGA || rx_byte == OPT_TTYPE)) begin
					push      = 1'b1;
					q_job.cmd = WILL;
				end else if (held_q == WILL || held_q == WONT) begin
					push = 1'b1;
					if (rx_byte == OPT_ECHO || rx_byte == OPT_SGA || rx_byte == OPT_TTYPE) begin
						q_job.cmd = DO;
					end else begin
						q_job.cmd = DONT;
					end
				end else if (held_q == DO || held_q == DONT) begin
					push      = 1'b1;
					q_job.cmd = WONT;
				end else if (held_q == SB) begin
					q_job.kind = JOB_TTYPE;
					if (sb_end) begin
						push = 1'b1;
					end else begin
						phase_d = PH_SB;
					end
				end
			end
			PH_SB: begin
				q_job.kind = JOB_TTYPE;
				if (sb_end) begin
					push    = 1'b1;
					phase_d = PH_DATA;
				end
			end
			default: begin
				phase_d = PH_DATA;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DATA;
			held_q  <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			if (phase_q == PH_CMD) begin
				held_q <= rx_byte;
			end
		end
	end

endmodule

### rtl/tor_queue.sv
// Small job queue between the front end and the back end.
// Depends on tor_pkg for the job type.
module tor_queue #(
	parameter int DEPTH = tor_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  tor_pkg::job_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output tor_pkg::job_t rd_data,
	output logic          empty
);
	import tor_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/tor_back.sv
// Back end: expands each queued job into output bytes through a registered
// output stage, one per cycle unless stalled. Needs tor_pkg and the assert macros.
`include "telnet_option_responder_assert.svh"

module tor_back (
	input  logic          clk,
	input  logic          arst_n,
	input  tor_pkg::job_t head,
	input  logic          q_empty,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          to_network,
	output logic          last
);
	import tor_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic             valid_q;
	logic [7:0]       byte_q;
	logic             net_q;
	logic             last_q;
	logic             can_load, load;
	logic [7:0]       item_byte;
	logic             item_net;
	logic             item_last;

	assign can_load = !valid_q || out_ready;
	assign load     = can_load && !q_empty;
	assign q_pop    = load && item_last;

	always_comb begin
		item_byte = head.data;
		item_net  = 1'b1;
		item_last = 1'b1;
		case (head.kind)
			JOB_PASS: begin
				item_net = 1'b0;
			end
			JOB_REPLY: begin
				item_last = (idx_q == REPLY_LAST_IDX);
				if (idx_q == '0) begin
					item_byte = IAC;
				end else if (idx_q == IDX_W'(1)) begin
					item_byte = head.cmd;
				end
			end
			JOB_TTYPE: begin
				item_byte = ttype_byte(idx_q);
				item_last = (idx_q == TTYPE_LAST_IDX);
			end
			default: begin
				item_byte = 8'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				idx_q <= '0;
			end else if (load) begin
				idx_q <= idx_q + 1'b1;
			end
			if (can_load) begin
				valid_q <= !q_empty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= item_byte;
			net_q  <= item_net;
			last_q <= item_last;
		end
	end

	assign out_valid  = valid_q;
	assign out_byte   = byte_q;
	assign to_network = net_q;
	assign last       = last_q;

	`TOR_ASSERT_IMP(a_mid_job_has_head, idx_q != '0, !q_empty, "job index set with queue empty")
	`TOR_ASSERT_IMP(a_reply_idx_range, !q_empty && head.kind == JOB_REPLY, idx_q <= REPLY_LAST_IDX, "reply index out of range")
	`TOR_ASSERT_IMP(a_pass_idx_zero, !q_empty && head.kind == JOB_PASS, idx_q == '0, "pass job with nonzero index")

endmodule

### rtl/telnet_option_responder.sv
// Top level of the telnet option responder.
// Instantiates tor_front, tor_queue and tor_back; depends on tor_pkg.
//
// Received telnet bytes arrive on the s_axis channel, one byte per transfer,
// with tlast marking the end of a network read. Results leave on m_axis:
// tdata is the byte, tuser is 1 when it is a reply for the network and 0
// when it goes to the terminal, tlast flags the final byte caused by one
// input transfer. Bytes that cause no result (IAC, command bytes, the body
// of a subnegotiation) are simply consumed.
//
// The front end classifies each input combinationally and takes one transfer
// per cycle as long as the job queue has room. A plain data byte reaches
// m_axis through the queue and the output register. While m_axis is ready
// the back end emits one output byte per cycle: a pass-through job yields
// one byte, an option reply three and the terminal-type reply ten, so the
// sustained rate is one input per cycle for plain data and is set by the
// back end's one-byte-per-cycle output register during replies.
//
// Reset clears the command phase, the held command, the queue and the
// output valid flag. When the receiver stalls, the output register holds
// its transfer, the queue fills, and s_axis_tready drops until space returns.
module telnet_option_responder #(
	parameter int QUEUE_DEPTH = tor_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	// Received bytes.
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] rx_byte
	input  logic       s_axis_tlast,  // end_of_read
	// Emitted bytes.
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic       m_axis_tuser,  // [0] to_network
	output logic       m_axis_tlast   // last
);
	import tor_pkg::*;

	// Jobs flow from the front end into the queue and out to the back end.
	job_t push_job, head_job;
	logic q_push, q_pop, q_full, q_empty;

	tor_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.rx_byte     (s_axis_tdata),
		.end_of_read (s_axis_tlast),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (push_job)
	);

	tor_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (push_job),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (head_job),
		.empty   (q_empty)
	);

	// The back end pops a job when its last output byte is loaded.
	tor_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_job),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (m_axis_tdata),
		.to_network (m_axis_tuser),
		.last       (m_axis_tlast)
	);

endmodule
